### rtl/stt_pkg.sv
package stt_pkg;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_WORD = 2'd1,
		MODE_STR  = 2'd2,
		MODE_CMT  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_WORD  = 2'd0,
		KIND_STR   = 2'd1,
		KIND_PUNCT = 2'd2
	} kind_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_NL     = 8'h0a;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_COLON  = 8'h3a;

	localparam int RUN_MAX = 3;

	typedef struct packed {
		logic [7:0] ch;
		kind_t      kind;
		logic       has;
		logic       st;
		logic       cl;
	} result_t;

	typedef struct packed {
		logic [1:0]                 cnt;
		result_t [RUN_MAX-1:0]      res;
	} run_t;

endpackage

### rtl/stt_decode.sv
module stt_decode (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      text_byte,
	output stt_pkg::run_t   run
);

	stt_pkg::mode_t mode_q;
	stt_pkg::mode_t mode_nx;
	logic           slash_q;
	logic           slash_nx;
	logic           is_sp;
	logic           is_pu;
	stt_pkg::result_t r_close;
	stt_pkg::result_t r_punct;
	stt_pkg::result_t r_wchar;

	always_comb begin
		is_sp = (text_byte <= stt_pkg::CH_SPACE) || text_byte[7];
		is_pu = text_byte inside {stt_pkg::CH_LBRACE, stt_pkg::CH_RBRACE,
			stt_pkg::CH_LPAREN, stt_pkg::CH_RPAREN, stt_pkg::CH_SQUOTE,
			stt_pkg::CH_COLON};
		r_close = '{ch: stt_pkg::CH_NUL, kind: stt_pkg::KIND_WORD,
			has: 1'b0, st: 1'b0, cl: 1'b1};
		r_punct = '{ch: text_byte, kind: stt_pkg::KIND_PUNCT,
			has: 1'b1, st: 1'b1, cl: 1'b1};
		r_wchar = '{ch: text_byte, kind: stt_pkg::KIND_WORD,
			has: 1'b1, st: 1'b0, cl: 1'b0};

		run      = '0;
		mode_nx  = mode_q;
		slash_nx = 1'b0;

		if (slash_q) begin
			if (text_byte == stt_pkg::CH_SLASH) begin
				mode_nx = stt_pkg::MODE_CMT;
			end else begin
				run.res[0] = '{ch: stt_pkg::CH_SLASH, kind: stt_pkg::KIND_WORD,
					has: 1'b1, st: 1'b1, cl: 1'b0};
				if (is_sp) begin
					run.res[1] = r_close;
					run.cnt    = 2'd2;
					mode_nx    = stt_pkg::MODE_IDLE;
				end else if (is_pu) begin
					run.res[1] = r_close;
					run.res[2] = r_punct;
					run.cnt    = 2'd3;
					mode_nx    = stt_pkg::MODE_IDLE;
				end else begin
					run.res[1] = r_wchar;
					run.cnt    = 2'd2;
					mode_nx    = stt_pkg::MODE_WORD;
				end
			end
		end else begin
			case (mode_q)
				stt_pkg::MODE_IDLE: begin
					if (is_sp) begin
						run.cnt = 2'd0;
					end else if (text_byte == stt_pkg::CH_SLASH) begin
						slash_nx = 1'b1;
					end else if (text_byte == stt_pkg::CH_DQUOTE) begin
						run.res[0] = '{ch: stt_pkg::CH_NUL, kind: stt_pkg::KIND_STR,
							has: 1'b0, st: 1'b1, cl: 1'b0};
						run.cnt    = 2'd1;
						mode_nx    = stt_pkg::MODE_STR;
					end else if (is_pu) begin
						run.res[0] = r_punct;
						run.cnt    = 2'd1;
					end else begin
						run.res[0]    = r_wchar;
						run.res[0].st = 1'b1;
						run.cnt       = 2'd1;
						mode_nx       = stt_pkg::MODE_WORD;
					end
				end
				stt_pkg::MODE_WORD: begin
					if (is_sp) begin
						run.res[0] = r_close;
						run.cnt    = 2'd1;
						mode_nx    = stt_pkg::MODE_IDLE;
					end else if (is_pu) begin
						run.res[0] = r_close;
						run.res[1] = r_punct;
						run.cnt    = 2'd2;
						mode_nx    = stt_pkg::MODE_IDLE;
					end else begin
						run.res[0] = r_wchar;
						run.cnt    = 2'd1;
					end
				end
				stt_pkg::MODE_STR: begin
					if (text_byte == stt_pkg::CH_DQUOTE || text_byte == stt_pkg::CH_NUL) begin
						run.res[0] = '{ch: stt_pkg::CH_NUL, kind: stt_pkg::KIND_STR,
							has: 1'b0, st: 1'b0, cl: 1'b1};
						run.cnt    = 2'd1;
						mode_nx    = stt_pkg::MODE_IDLE;
					end else begin
						run.res[0] = '{ch: text_byte, kind: stt_pkg::KIND_STR,
							has: 1'b1, st: 1'b0, cl: 1'b0};
						run.cnt    = 2'd1;
					end
				end
				default: begin
					if (text_byte == stt_pkg::CH_NL || text_byte == stt_pkg::CH_NUL) begin
						mode_nx = stt_pkg::MODE_IDLE;
					end
				end
			endcase
		end

		if (text_byte == stt_pkg::CH_NUL) begin
			mode_nx  = stt_pkg::MODE_IDLE;
			slash_nx = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= stt_pkg::MODE_IDLE;
			slash_q <= 1'b0;
		end else if (accept) begin
			mode_q  <= mode_nx;
			slash_q <= slash_nx;
		end
	end

`ifndef ASSERT_OFF
	a_slash_idle: assert property (@(posedge clk) disable iff (!arst_n)
		slash_q |-> mode_q == stt_pkg::MODE_IDLE)
		else $error("held slash outside idle mode");
	a_three_need_slash: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && run.cnt == 2'd3) |-> slash_q)
		else $error("three-result run without held slash");
	a_nul_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && text_byte == stt_pkg::CH_NUL) |=>
		(mode_q == stt_pkg::MODE_IDLE && !slash_q))
		else $error("end of text did not reset lexer");
`endif

endmodule

### rtl/stt_emit.sv
module stt_emit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  stt_pkg::run_t   run,
	output logic            can_load,
	output logic            token_valid,
	input  logic            token_stall,
	output logic [7:0]      token_char,
	output logic [1:0]      token_kind,
	output logic            has_char,
	output logic            starts_token,
	output logic            closes_token,
	output logic            last_of_run
);

	stt_pkg::result_t [stt_pkg::RUN_MAX-1:0] slot_q;
	logic [1:0] cnt_q;
	logic       take;

	assign token_valid  = (cnt_q != 2'd0);
	assign take         = token_valid && !token_stall;
	assign can_load     = (cnt_q == 2'd0) || (cnt_q == 2'd1 && !token_stall);
	assign token_char   = slot_q[0].ch;
	assign token_kind   = slot_q[0].kind;
	assign has_char     = slot_q[0].has;
	assign starts_token = slot_q[0].st;
	assign closes_token = slot_q[0].cl;
	assign last_of_run  = (cnt_q == 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= run.cnt;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= run.res;
		end else if (take) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

`ifndef ASSERT_OFF
	a_three_slash_first: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd3 |-> (slot_q[0].has && slot_q[0].ch == stt_pkg::CH_SLASH))
		else $error("three-result run not led by slash");
`endif

endmodule

### rtl/script_text_tokenizer.sv
// Latency: first result of a byte is presented the cycle after the byte is taken.
// Throughput: one byte per cycle while each byte gives at most one result and
// the receiver takes every result.
// A byte giving several results presents them in order, holding each until it is taken;
// input stalls until its last result is taken.
// Reset (arst_n low) clears lexer mode and held slash and empties the result buffer.
module script_text_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_valid,
	output logic        text_stall,
	input  logic [7:0]  text_byte,
	output logic        token_valid,
	input  logic        token_stall,
	output logic [7:0]  token_char,
	output logic [1:0]  token_kind,
	output logic        has_char,
	output logic        starts_token,
	output logic        closes_token,
	output logic        last_of_run
);

	stt_pkg::run_t run;
	logic          can_load;
	logic          accept;

	assign text_stall = !can_load;
	assign accept     = text_valid && can_load;

	stt_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.text_byte (text_byte),
		.run       (run)
	);

	stt_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept),
		.run          (run),
		.can_load     (can_load),
		.token_valid  (token_valid),
		.token_stall  (token_stall),
		.token_char   (token_char),
		.token_kind   (token_kind),
		.has_char     (has_char),
		.starts_token (starts_token),
		.closes_token (closes_token),
		.last_of_run  (last_of_run)
	);

endmodule

### verif/tb_script_text_tokenizer.sv
module tb_script_text_tokenizer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_CYCLES   = 200;
	localparam int PHASE_BYTES   = 100;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [7:0]     ch;
		stt_pkg::kind_t kind;
		logic           has;
		logic           st;
		logic           cl;
		logic           last;
	} token_rec_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       text_valid = 1'b0;
	logic       text_stall;
	logic [7:0] text_byte = 8'h00;
	logic       token_valid;
	logic       token_stall = 1'b0;
	logic [7:0] token_char;
	logic [1:0] token_kind;
	logic       has_char;
	logic       starts_token;
	logic       closes_token;
	logic       last_of_run;

	token_rec_t     pending_tokens[$];
	stt_pkg::mode_t lex_state = stt_pkg::MODE_IDLE;
	logic           slash_held = 1'b0;

	int  cycle_count = 0;
	int  mismatches = 0;
	int  bytes_sent = 0;
	int  results_seen = 0;
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	logic stall_hold = 1'b0;

	script_text_tokenizer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_stall   (text_stall),
		.text_byte    (text_byte),
		.token_valid  (token_valid),
		.token_stall  (token_stall),
		.token_char   (token_char),
		.token_kind   (token_kind),
		.has_char     (has_char),
		.starts_token (starts_token),
		.closes_token (closes_token),
		.last_of_run  (last_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still pending",
				cycle_count, pending_tokens.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		token_stall <= stall_hold || ($urandom_range(99) < recv_stall_pct);
	end

	function automatic bit is_blank(logic [7:0] b);
		return (b <= stt_pkg::CH_SPACE) || b[7];
	endfunction

	function automatic bit is_punct(logic [7:0] b);
		return b inside {stt_pkg::CH_LBRACE, stt_pkg::CH_RBRACE, stt_pkg::CH_LPAREN,
			stt_pkg::CH_RPAREN, stt_pkg::CH_SQUOTE, stt_pkg::CH_COLON};
	endfunction

	function automatic void emit(logic [7:0] ch, stt_pkg::kind_t kind, logic has,
			logic st, logic cl);
		token_rec_t r;
		r.ch   = ch;
		r.kind = kind;
		r.has  = has;
		r.st   = st;
		r.cl   = cl;
		r.last = 1'b0;
		pending_tokens.push_back(r);
	endfunction

	function automatic void word_step(logic [7:0] b);
		if (is_blank(b)) begin
			emit(stt_pkg::CH_NUL, stt_pkg::KIND_WORD, 1'b0, 1'b0, 1'b1);
			lex_state = stt_pkg::MODE_IDLE;
		end else if (is_punct(b)) begin
			emit(stt_pkg::CH_NUL, stt_pkg::KIND_WORD, 1'b0, 1'b0, 1'b1);
			emit(b, stt_pkg::KIND_PUNCT, 1'b1, 1'b1, 1'b1);
			lex_state = stt_pkg::MODE_IDLE;
		end else begin
			emit(b, stt_pkg::KIND_WORD, 1'b1, 1'b0, 1'b0);
		end
	endfunction

	function automatic void tokenize_byte(logic [7:0] b);
		int first;
		first = pending_tokens.size();
		if (slash_held) begin
			slash_held = 1'b0;
			if (b == stt_pkg::CH_SLASH) begin
				lex_state = stt_pkg::MODE_CMT;
				return;
			end
			emit(stt_pkg::CH_SLASH, stt_pkg::KIND_WORD, 1'b1, 1'b1, 1'b0);
			lex_state = stt_pkg::MODE_WORD;
			word_step(b);
		end else begin
			case (lex_state)
				stt_pkg::MODE_IDLE: begin
					if (is_blank(b)) begin
					end else if (b == stt_pkg::CH_SLASH) begin
						slash_held = 1'b1;
					end else if (b == stt_pkg::CH_DQUOTE) begin
						emit(stt_pkg::CH_NUL, stt_pkg::KIND_STR, 1'b0, 1'b1, 1'b0);
						lex_state = stt_pkg::MODE_STR;
					end else if (is_punct(b)) begin
						emit(b, stt_pkg::KIND_PUNCT, 1'b1, 1'b1, 1'b1);
					end else begin
						emit(b, stt_pkg::KIND_WORD, 1'b1, 1'b1, 1'b0);
						lex_state = stt_pkg::MODE_WORD;
					end
				end
				stt_pkg::MODE_WORD: word_step(b);
				stt_pkg::MODE_STR: begin
					if (b == stt_pkg::CH_DQUOTE || b == stt_pkg::CH_NUL) begin
						emit(stt_pkg::CH_NUL, stt_pkg::KIND_STR, 1'b0, 1'b0, 1'b1);
						lex_state = stt_pkg::MODE_IDLE;
					end else begin
						emit(b, stt_pkg::KIND_STR, 1'b1, 1'b0, 1'b0);
					end
				end
				default: begin
					if (b == stt_pkg::CH_NL || b == stt_pkg::CH_NUL)
						lex_state = stt_pkg::MODE_IDLE;
				end
			endcase
		end
		if (b == stt_pkg::CH_NUL) begin
			lex_state = stt_pkg::MODE_IDLE;
			slash_held = 1'b0;
		end
		if (pending_tokens.size() > first)
			pending_tokens[$].last = 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s got %0h expected %0h",
				results_seen, name, got, want));
	endtask

	always @(posedge clk) begin
		token_rec_t want;
		if (arst_n && token_valid && !token_stall) begin
			if (pending_tokens.size() == 0) begin
				report_mismatch($sformatf("unexpected result char %0h", token_char));
			end else begin
				want = pending_tokens.pop_front();
				check_field("token_char", token_char, want.ch);
				check_field("token_kind", {6'd0, token_kind}, {6'd0, want.kind});
				check_field("has_char", {7'd0, has_char}, {7'd0, want.has});
				check_field("starts_token", {7'd0, starts_token}, {7'd0, want.st});
				check_field("closes_token", {7'd0, closes_token}, {7'd0, want.cl});
				check_field("last_of_run", {7'd0, last_of_run}, {7'd0, want.last});
			end
			results_seen++;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		text_valid <= 1'b1;
		text_byte <= b;
		@(posedge clk);
		while (text_stall)
			@(posedge clk);
		tokenize_byte(b);
		bytes_sent++;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_text(input string s);
		foreach (s[i])
			send_byte(s[i]);
	endtask

	task automatic drain();
		text_valid <= 1'b0;
		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_word_char(bit first);
		logic [7:0] b;
		do begin
			b = 8'($urandom_range(33, 127));
		end while (is_punct(b) ||
			(first && (b == stt_pkg::CH_SLASH || b == stt_pkg::CH_DQUOTE)));
		return b;
	endfunction

	function automatic logic [7:0] rand_blank();
		if ($urandom_range(1))
			return 8'($urandom_range(1, 32));
		return 8'($urandom_range(128, 255));
	endfunction

	function automatic logic [7:0] rand_punct();
		case ($urandom_range(5))
			0: return stt_pkg::CH_LBRACE;
			1: return stt_pkg::CH_RBRACE;
			2: return stt_pkg::CH_LPAREN;
			3: return stt_pkg::CH_RPAREN;
			4: return stt_pkg::CH_SQUOTE;
			default: return stt_pkg::CH_COLON;
		endcase
	endfunction

	task automatic send_random_chunk();
		int pick;
		int len;
		logic [7:0] b;
		pick = $urandom_range(99);
		if (pick < 30) begin
			len = $urandom_range(1, 6);
			send_byte(rand_word_char(1'b1));
			repeat (len - 1) send_byte(rand_word_char(1'b0));
			send_byte($urandom_range(1) ? rand_blank() : rand_punct());
		end else if (pick < 45) begin
			len = $urandom_range(0, 6);
			send_byte(stt_pkg::CH_DQUOTE);
			repeat (len) begin
				do b = 8'($urandom_range(1, 255)); while (b == stt_pkg::CH_DQUOTE);
				send_byte(b);
			end
			send_byte(stt_pkg::CH_DQUOTE);
		end else if (pick < 57) begin
			send_byte(rand_punct());
		end else if (pick < 67) begin
			len = $urandom_range(0, 5);
			send_byte(stt_pkg::CH_SLASH);
			send_byte(stt_pkg::CH_SLASH);
			repeat (len) begin
				do b = 8'($urandom_range(1, 255)); while (b == stt_pkg::CH_NL);
				send_byte(b);
			end
			send_byte(stt_pkg::CH_NL);
		end else if (pick < 77) begin
			repeat ($urandom_range(1, 3)) send_byte(rand_blank());
		end else if (pick < 83) begin
			send_byte(stt_pkg::CH_SLASH);
			send_byte(8'($urandom_range(0, 255)));
		end else if (pick < 88) begin
			send_byte(stt_pkg::CH_NUL);
		end else begin
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic test_words();
		send_text("!a");
		send_byte(8'h7f);
		send_byte(8'h80);
		send_text("b:");
		send_byte(8'hff);
	endtask

	task automatic test_punctuation();
		send_text("{}()'");
	endtask

	task automatic test_strings();
		send_text("\"\"");
		send_byte(stt_pkg::CH_DQUOTE);
		send_byte(8'hff);
		send_byte(stt_pkg::CH_NL);
		send_byte(stt_pkg::CH_DQUOTE);
	endtask

	task automatic test_slash();
		send_text("/x ");
		send_text("/{");
		send_text("//z\n");
	endtask

	task automatic test_end_of_text();
		send_byte("q");
		send_byte(stt_pkg::CH_NUL);
		send_byte(stt_pkg::CH_SLASH);
		send_byte(stt_pkg::CH_NUL);
		send_byte(stt_pkg::CH_DQUOTE);
		send_byte(stt_pkg::CH_NUL);
		send_text("//");
		send_byte(stt_pkg::CH_NUL);
		drain();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fork
			begin
				stall_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				stall_hold <= 1'b0;
			end
			begin
				repeat (20) send_text("a{");
			end
		join
		drain();
	endtask

	task automatic test_random(input int idle_pct, input int stall_pct);
		int goal;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		goal = bytes_sent + PHASE_BYTES;
		while (bytes_sent < goal)
			send_random_chunk();
		send_byte(stt_pkg::CH_NUL);
		drain();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_words();
		test_punctuation();
		test_strings();
		test_slash();
		test_end_of_text();
		test_backpressure();
		test_random(0, 0);
		test_random(65, 0);
		test_random(0, 65);
		test_random(7, 7);
		$display("Covered %0d text bytes giving %0d token results: words, strings, comments,",
			bytes_sent, results_seen);
		$display("punctuation, held slashes, end of text, four idle mixes and one long hold.");
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

### files.f
rtl/stt_pkg.sv
rtl/stt_decode.sv
rtl/stt_emit.sv
rtl/script_text_tokenizer.sv
verif/tb_script_text_tokenizer.sv
